// ----- rtl/rsas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rsas_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = 32;
    localparam int LENW  = 11;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [DW-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic          found;
        logic [AW-1:0] index;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/rsas_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsas_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/rsas_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsas_ctrl
    import rsas_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_opcode,
    input  wire logic [AW-1:0]   i_entry_index,
    input  wire logic [DW-1:0]   i_entry_value,
    input  wire logic [DW-1:0]   i_target,
    input  wire logic [LENW-1:0] i_length,
    output t_mem_req             o_mem_req,
    input  wire logic [DW-1:0]   i_rd_data,
    output logic                 o_res_valid,
    output t_result              o_res,
    input  wire logic            i_res_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MID  = 3'd1;
    localparam logic [2:0] S_LO   = 3'd2;
    localparam logic [2:0] S_HI   = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_LAST = 3'd5;
    localparam logic [2:0] S_CHK  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]            r_state, n_state;
    logic [AW-1:0]         r_lo, n_lo;
    logic [AW-1:0]         r_hi, n_hi;
    logic [AW-1:0]         r_mid, n_mid;
    logic signed [DW-1:0]  r_tgt, n_tgt;
    logic signed [DW-1:0]  r_vmid, n_vmid;
    logic signed [DW-1:0]  r_vlo, n_vlo;
    t_result               r_res, n_res;

    logic                  w_accept;
    logic [LENW-1:0]       w_len;
    logic [AW:0]           w_sum;
    logic [AW-1:0]         w_mid;
    logic signed [DW-1:0]  w_vhi;
    logic [AW-1:0]         w_new_lo;
    logic [AW-1:0]         w_new_hi;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // saturate the searched length to the array depth
    assign w_len      = (i_length > LENW'(DEPTH)) ? LENW'(DEPTH) : i_length;
    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[AW:1];
    assign w_vhi      = i_rd_data;

    // narrow toward the half that can hold the target
    always_comb begin
        w_new_lo = r_lo;
        w_new_hi = r_hi;
        if (r_vlo <= r_vmid) begin
            if (r_tgt >= r_vlo && r_tgt < r_vmid) begin
                w_new_hi = r_mid - AW'(1);
            end else begin
                w_new_lo = r_mid + AW'(1);
            end
        end else begin
            if (r_tgt > r_vmid && r_tgt <= w_vhi) begin
                w_new_lo = r_mid + AW'(1);
            end else begin
                w_new_hi = r_mid - AW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_tgt   = r_tgt;
        n_vmid  = r_vmid;
        n_vlo   = r_vlo;
        n_res   = r_res;
        o_mem_req.we    = 1'b0;
        o_mem_req.addr  = r_lo;
        o_mem_req.wdata = i_entry_value;
        case (r_state)
            S_IDLE: begin
                o_mem_req.addr = i_entry_index;
                if (w_accept) begin
                    if (i_opcode == OP_WRITE) begin
                        o_mem_req.we = 1'b1;
                    end else begin
                        n_tgt = i_target;
                        n_lo  = '0;
                        n_hi  = AW'(w_len - LENW'(1));
                        if (w_len == '0) begin
                            n_res   = '0;
                            n_state = S_DONE;
                        end else if (w_len == LENW'(1)) begin
                            n_state = S_LAST;
                        end else begin
                            n_state = S_MID;
                        end
                    end
                end
            end
            S_MID: begin
                o_mem_req.addr = w_mid;
                n_mid          = w_mid;
                n_state        = S_LO;
            end
            S_LO: begin
                o_mem_req.addr = r_lo;
                n_vmid         = i_rd_data;
                n_state        = S_HI;
            end
            S_HI: begin
                o_mem_req.addr = r_hi;
                n_vlo          = i_rd_data;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                if (r_vmid == r_tgt) begin
                    n_res.found = 1'b1;
                    n_res.index = r_mid;
                    n_state     = S_DONE;
                end else begin
                    n_lo    = w_new_lo;
                    n_hi    = w_new_hi;
                    n_state = (w_new_lo < w_new_hi) ? S_MID : S_LAST;
                end
            end
            S_LAST: begin
                o_mem_req.addr = r_lo;
                n_state        = S_CHK;
            end
            S_CHK: begin
                n_res.found = ($signed(i_rd_data) == r_tgt);
                n_res.index = ($signed(i_rd_data) == r_tgt) ? r_lo : '0;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lo    <= '0;
            r_hi    <= '0;
        end else begin
            r_state <= n_state;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid  <= n_mid;
        r_tgt  <= n_tgt;
        r_vmid <= n_vmid;
        r_vlo  <= n_vlo;
        r_res  <= n_res;
    end

    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ----- rtl/rotated_sorted_array_search.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// s_t*      in         tuser: opcode; tdata: entry_index, entry_value, target
// m_t*      out        tuser: found;  tdata: found_index
// cfg_*     in         cfg_data: length_in_use
//
// A write goes to the entry memory in its accept cycle. A search takes the accept cycle, then per halving
// step one memory read each of mid, low and high entries plus the decision, then
// a read and check of the final low entry and a hand-off state; it ends early on a
// hit at mid. The single-port entry memory makes these reads one after another.
// Reset is synchronous, active low; the entry memory is not cleared.
// The result register lets the next item enter while a result waits on m_tready.

module rotated_sorted_array_search
    import rsas_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [79:0]     s_tdata,  // entry_index, entry_value, target, zero pad
    input  wire logic            s_tuser,  // opcode
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic      [15:0]     m_tdata,  // found_index, zero pad
    output logic                 m_tuser,  // found
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [LENW-1:0] cfg_data
);

    logic [LENW-1:0] r_length;
    logic            r_m_valid;
    t_result         r_m_res;

    t_mem_req        w_mem_req;
    logic [DW-1:0]   w_rd_data;
    logic            w_res_valid;
    t_result         w_res;
    logic            w_res_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
        end else if (cfg_valid && cfg_ready) begin
            r_length <= cfg_data;
        end
    end

    rsas_ram #(
        .ADDR_W (AW),
        .DATA_W (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_req.we),
        .i_addr  (w_mem_req.addr),
        .i_wdata (w_mem_req.wdata),
        .o_rdata (w_rd_data)
    );

    rsas_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_tvalid),
        .o_in_ready    (s_tready),
        .i_opcode      (s_tuser),
        .i_entry_index (s_tdata[AW-1:0]),
        .i_entry_value (s_tdata[AW+DW-1:AW]),
        .i_target      (s_tdata[AW+2*DW-1:AW+DW]),
        .i_length      (r_length),
        .o_mem_req     (w_mem_req),
        .i_rd_data     (w_rd_data),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res),
        .i_res_ready   (w_res_ready)
    );

    // advance into the output register when it is empty or being drained
    assign w_res_ready = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_res.found;
    assign m_tdata  = {{(16-AW){1'b0}}, r_m_res.index};

endmodule

`default_nettype wire

// ----- rtl/rsas_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsas_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 16'd0)
        else $error("miss carries a nonzero index");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[15:10] == 6'd0)
        else $error("index pad bits set");

    // a search occupies the block for at least the next cycle
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken right after a search transfer");

endmodule

bind rotated_sorted_array_search rsas_checker u_rsas_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import rsas_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_200_000;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned ITEM_GOAL     = 1670;
    localparam logic signed [DW-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DW-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // Mirror of the entry store and length register; computes each search answer.
    class search_tracker;
        logic signed [DW-1:0] image [DEPTH];
        logic [LENW-1:0]      length_reg;
        t_result              pending_answers [$];
        int unsigned          mismatches, results_seen, hits, writes_seen, searches_seen;

        function new();
            foreach (image[i]) image[i] = '0;
            length_reg    = '0;
            mismatches    = 0;
            results_seen  = 0;
            hits          = 0;
            writes_seen   = 0;
            searches_seen = 0;
        endfunction

        function void set_length(logic [LENW-1:0] v);
            length_reg = v;
        endfunction

        function int unsigned pending();
            return pending_answers.size();
        endfunction

        function t_result locate_key(logic signed [DW-1:0] key);
            t_result     res;
            int unsigned n, lo, hi, mid;
            res = '0;
            n   = (length_reg > DEPTH) ? DEPTH : length_reg;
            if (n == 0) return res;
            lo = 0;
            hi = n - 1;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (image[mid] == key) begin
                    res.found = 1'b1;
                    res.index = mid[AW-1:0];
                    return res;
                end
                // keep the half that can still hold the key
                if (image[lo] <= image[mid]) begin
                    if (key >= image[lo] && key < image[mid]) hi = mid - 1;
                    else lo = mid + 1;
                end else begin
                    if (key > image[mid] && key <= image[hi]) lo = mid + 1;
                    else hi = mid - 1;
                end
            end
            if (image[lo] == key) begin
                res.found = 1'b1;
                res.index = lo[AW-1:0];
            end
            return res;
        endfunction

        function void note_input(logic op, logic [AW-1:0] idx, logic signed [DW-1:0] val,
                                 logic signed [DW-1:0] key);
            if (op == OP_WRITE) begin
                image[idx] = val;
                writes_seen++;
            end else begin
                pending_answers.push_back(locate_key(key));
                searches_seen++;
            end
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH %s", msg);
        endfunction

        function void check_result(logic got_found, logic [AW-1:0] got_index);
            t_result want;
            results_seen++;
            if (pending_answers.size() == 0) begin
                report($sformatf("answer %0d arrived with none expected: found=%0d index=%0d",
                                 results_seen, got_found, got_index));
                return;
            end
            want = pending_answers.pop_front();
            if (got_found !== want.found)
                report($sformatf("answer %0d: found expected %0d, actual %0d",
                                 results_seen, want.found, got_found));
            if (got_index !== want.index)
                report($sformatf("answer %0d: index expected %0d, actual %0d",
                                 results_seen, want.index, got_index));
            if (want.found) hits++;
        endfunction
    endclass

    logic             i_clk    = 1'b0;
    logic             i_rst_n  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [79:0]      s_tdata  = '0;  // entry_index, entry_value, target, zero pad
    logic             s_tuser  = 1'b0;  // opcode
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;  // found_index, zero pad
    logic             m_tuser;  // found
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LENW-1:0]  cfg_data  = '0;

    search_tracker tracker = new();

    bit          tx_calm;
    bit          rx_calm;
    int unsigned rx_hold_cycles;
    int unsigned items_sent;
    int unsigned cfg_writes;
    int unsigned cycle_count;
    int          layout [$];

    rotated_sorted_array_search DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) tracker.check_result(m_tuser, m_tdata[AW-1:0]);
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    initial begin : rx_side
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    task automatic send_item(input logic op, input logic [AW-1:0] idx,
                             input logic [DW-1:0] val, input logic [DW-1:0] key);
        int unsigned gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, key, val, idx};
        do @(posedge i_clk); while (!s_tready);
        tracker.note_input(op, idx, val, key);
        items_sent++;
    endtask

    task automatic write_entry(input int unsigned idx, input int val);
        send_item(OP_WRITE, idx[AW-1:0], val, $urandom);
    endtask

    task automatic search_for(input int key);
        send_item(OP_SEARCH, AW'($urandom_range(0, DEPTH - 1)), $urandom, key);
    endtask

    // Drain all answers, let the block settle, then transfer one length write.
    task automatic set_length(input int unsigned v);
        s_tvalid <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[LENW-1:0];
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_length(v[LENW-1:0]);
        cfg_writes++;
    endtask

    // Ascending distinct values rotated at a random pivot, or junk when noisy.
    task automatic build_layout(input int unsigned n, input bit noisy);
        int          sorted_q [$];
        int          hit_q [$];
        int          v;
        int          base;
        int unsigned r, i;
        sorted_q.delete();
        layout.delete();
        if (noisy) begin
            repeat (n)
                layout.push_back(($urandom_range(0, 3) == 0) ? int'($urandom)
                                                             : int'($urandom_range(0, 7)) - 4);
            return;
        end
        if ($urandom_range(0, 1) == 1) begin
            while (sorted_q.size() < n) begin
                v = $urandom;
                hit_q = sorted_q.find_index(x) with (x == v);
                if (hit_q.size() == 0) sorted_q.push_back(v);
            end
            sorted_q.sort();
        end else begin
            case ($urandom_range(0, 2))
                0: base = VAL_MIN;
                1: base = VAL_MAX - 4 * int'(n);
                default: base = int'($urandom_range(0, 2000000)) - 1000000;
            endcase
            v = base;
            repeat (n) begin
                sorted_q.push_back(v);
                v += $urandom_range(1, 4);
            end
        end
        r = $urandom_range(0, n - 1);
        for (i = 0; i < n; i++) layout.push_back(sorted_q[(i + r) % n]);
    endtask

    function automatic int pick_target();
        int unsigned r;
        int          pick;
        r = $urandom_range(0, 99);
        if (layout.size() == 0) return $urandom;
        pick = layout[$urandom_range(0, layout.size() - 1)];
        if (r < 60) return pick;
        if (r < 75) return ($urandom_range(0, 1) == 1) ? pick + 1 : pick - 1;
        if (r < 90) return $urandom;
        if (r < 95) return VAL_MIN;
        return VAL_MAX;
    endfunction

    initial begin : tx_side
        int unsigned n, len, count, phase, idx, i;
        int unsigned order_q [$];
        bit          noisy;
        int          val;

        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        rx_hold_cycles = 0;
        items_sent     = 0;
        cfg_writes     = 0;
        cycle_count    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty array
        set_length(0);
        search_for(0);
        search_for(-1);

        // single entry holding the most negative value
        write_entry(0, VAL_MIN);
        set_length(1);
        search_for(VAL_MIN);
        search_for(VAL_MAX);

        // short rotated array spanning both extremes
        layout = {3, VAL_MAX, VAL_MIN, -5, 0};
        for (i = 0; i < 5; i++) write_entry(i, layout[i]);
        write_entry(DEPTH - 1, -1);
        set_length(5);
        for (i = 0; i < 5; i++) search_for(layout[i]);
        search_for(1);
        search_for(-6);

        // fill the whole store once; later phases rewrite a prefix and, now and then, single entries anywhere
        build_layout(DEPTH, 1'b0);
        order_q.delete();
        for (i = 0; i < DEPTH; i++) order_q.push_back(i);
        order_q.shuffle();
        foreach (order_q[k]) write_entry(order_q[k], layout[order_q[k]]);
        set_length(DEPTH);
        repeat (12) search_for(pick_target());
        set_length((1 << LENW) - 1);
        search_for(layout[0]);
        search_for(layout[DEPTH - 1]);
        repeat (6) search_for(pick_target());

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            n       = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 200)
                                                  : $urandom_range(1, 32);
            noisy   = ($urandom_range(0, 6) == 0);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            build_layout(n, noisy);
            order_q.delete();
            for (i = 0; i < n; i++) order_q.push_back(i);
            if ($urandom_range(0, 1) == 1) order_q.shuffle();
            foreach (order_q[k]) write_entry(order_q[k], layout[order_q[k]]);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : n;
            set_length(len);
            // back up the block: receiver holds off while searches keep coming
            if (phase == 2) begin
                tx_calm        = 1'b1;
                rx_hold_cycles = 500;
            end
            count = $urandom_range(4, 2 * n + 6);
            if (count > 40) count = 40;
            repeat (count) begin
                if ($urandom_range(0, 19) == 0) begin
                    idx = $urandom_range(0, DEPTH - 1);
                    val = (idx < n && $urandom_range(0, 1) == 1) ? layout[idx] : int'($urandom);
                    if (idx < n) layout[idx] = val;
                    write_entry(idx, val);
                end else begin
                    search_for(pick_target());
                end
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run: %0d entry writes, %0d searches, %0d length settings incl. 0, 1024, 2047",
                 tracker.writes_seen, tracker.searches_seen, cfg_writes);
        $display("Answers: %0d checked, %0d hits, %0d mismatches",
                 tracker.results_seen, tracker.hits, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rsas_pkg.sv
rtl/rsas_ram.sv
rtl/rsas_ctrl.sv
rtl/rotated_sorted_array_search.sv
rtl/rsas_checker.sv
verif/testbench.sv
